>>> hw/rtl/sorpcu_pkg.sv
// Shared types and constants of the pressure cell update core.
`timescale 1ns / 1ps

package sorpcu_pkg;

  // Pipeline control that each arithmetic unit receives from the core.
  typedef struct packed {
    logic en;   // all stages advance in this cycle
    logic vld;  // an item enters the unit in this cycle
  } stage_ctl_t;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 47;

  localparam logic [CFG_IDX_W-1:0] REG_RELAXATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_DX_SQ  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_DY_SQ  = 2'd2;

  // Register widths and reset values (omega = 1.7, 1/dx^2 = 1/dy^2 = 1.0).
  localparam int RELAX_W  = 26;
  localparam int INV_SQ_W = 47;

  localparam logic [RELAX_W-1:0]  RELAX_RESET  = 26'd28521267;
  localparam logic [INV_SQ_W-1:0] INV_SQ_RESET = 47'd16777216;

  // Input flag positions in the slave-side tuser.
  localparam int FLAG_CENTER = 0;
  localparam int FLAG_EAST   = 1;
  localparam int FLAG_WEST   = 2;
  localparam int FLAG_NORTH  = 3;
  localparam int FLAG_SOUTH  = 4;
  localparam int IN_USER_W   = 5;

endpackage

>>> hw/rtl/sorpcu_mul.sv
// Two-stage fixed-point multiplier with rounding and saturation.
`timescale 1ns / 1ps

module sorpcu_mul #(
  parameter int W      = 48,
  parameter int F      = 24,
  parameter int SIDE_W = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sorpcu_pkg::stage_ctl_t ctl_i,
  input  logic [W-1:0]           a_i,
  input  logic [W-1:0]           b_i,
  input  logic [SIDE_W-1:0]      side_i,
  output logic [W-1:0]           p_o,
  output logic [SIDE_W-1:0]      side_o,
  output logic                   vld_o
);

  localparam int H  = (W + 1) / 2;
  localparam int L  = W - H;
  localparam int P2 = 2 * W + 1;
  localparam int WLL = 2 * H;
  localparam int WLH = H + L;
  localparam int WHH = 2 * L;

  localparam logic [W-1:0]  VMAX   = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  VMIN   = {1'b1, {(W-1){1'b0}}};
  localparam logic [P2-1:0] VMAX_X = P2'(VMAX);
  localparam logic [P2-1:0] HALF   = P2'(1) << (F - 1);

  logic [W-1:0]     mag_a, mag_b;
  logic [WLL-1:0]   ll_q;
  logic [WLH-1:0]   lh_q, hl_q;
  logic [WHH-1:0]   hh_q;
  logic             neg_q;
  logic [SIDE_W-1:0] side1_q;
  logic             vld1_q;
  logic [P2-1:0]    prod, scaled;
  logic             sat;
  logic [W-1:0]     p_d, p_q;
  logic [SIDE_W-1:0] side2_q;
  logic             vld2_q;

  // Magnitudes of both operands; the most negative value maps to 2^(W-1).
  assign mag_a = a_i[W-1] ? (~a_i + W'(1)) : a_i;
  assign mag_b = b_i[W-1] ? (~b_i + W'(1)) : b_i;

  // First stage: four partial products.
  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      ll_q    <= WLL'(mag_a[H-1:0]) * WLL'(mag_b[H-1:0]);
      lh_q    <= WLH'(mag_a[H-1:0]) * WLH'(mag_b[W-1:H]);
      hl_q    <= WLH'(mag_a[W-1:H]) * WLH'(mag_b[H-1:0]);
      hh_q    <= WHH'(mag_a[W-1:H]) * WHH'(mag_b[W-1:H]);
      neg_q   <= a_i[W-1] ^ b_i[W-1];
      side1_q <= side_i;
    end
  end

  // Second stage: sum, round half away from zero, scale and saturate.
  always_comb begin
    prod   = P2'(ll_q) + (P2'(lh_q) << H) + (P2'(hl_q) << H) + (P2'(hh_q) << (2 * H)) + HALF;
    scaled = prod >> F;
    sat    = scaled > VMAX_X;
    if (neg_q) begin
      p_d = sat ? VMIN : (~scaled[W-1:0] + W'(1));
    end else begin
      p_d = sat ? VMAX : scaled[W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      p_q     <= p_d;
      side2_q <= side1_q;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (ctl_i.en) begin
      vld1_q <= ctl_i.vld;
      vld2_q <= vld1_q;
    end
  end

  assign p_o    = p_q;
  assign side_o = side2_q;
  assign vld_o  = vld2_q;

endmodule

>>> hw/rtl/sorpcu_div.sv
// Pipelined fixed-point divider, one quotient bit per stage, with rounding.
`timescale 1ns / 1ps

module sorpcu_div #(
  parameter int W      = 48,
  parameter int F      = 24,
  parameter int SIDE_W = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sorpcu_pkg::stage_ctl_t ctl_i,
  input  logic [W-1:0]           num_i,
  input  logic [W-1:0]           den_i,
  input  logic [SIDE_W-1:0]      side_i,
  output logic [W-1:0]           quo_o,
  output logic [SIDE_W-1:0]      side_o,
  output logic                   vld_o
);

  localparam logic [W-1:0] VMAX   = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMIN   = {1'b1, {(W-1){1'b0}}};
  localparam logic [W:0]   VMAX_X = {1'b0, VMAX};

  logic [W-1:0]      rem_q  [W+1];
  logic [W-1:0]      nlo_q  [W+1];
  logic [W-1:0]      quo_q  [W+1];
  logic [W-1:0]      den_q  [W+1];
  logic              neg_q  [W+1];
  logic              over_q [W+1];
  logic [SIDE_W-1:0] side_q [W+1];
  logic              vld_q  [W+1];

  logic [W-1:0]      mag;
  logic [W-1:0]      head;
  logic              rnd, sat;
  logic [W:0]        quo_rnd;
  logic [W-1:0]      res_d, res_q;
  logic [SIDE_W-1:0] side_out_q;
  logic              vld_out_q;

  // Entry: the numerator magnitude shifted by F bits; the part above W bits
  // seeds the remainder, and a quotient of 2^W or more saturates at once.
  assign mag  = num_i[W-1] ? (~num_i + W'(1)) : num_i;
  assign head = mag >> (W - F);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      rem_q[0]  <= head;
      nlo_q[0]  <= mag << F;
      quo_q[0]  <= '0;
      den_q[0]  <= den_i;
      neg_q[0]  <= num_i[W-1];
      over_q[0] <= head >= den_i;
      side_q[0] <= side_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (ctl_i.en) begin
      vld_q[0] <= ctl_i.vld;
    end
  end

  // Restoring division, one bit per stage.
  for (genvar k = 0; k < W; k++) begin : g_bit
    logic [W:0] trial;
    logic       ge;

    assign trial = {rem_q[k], nlo_q[k][W-1]};
    assign ge    = trial >= {1'b0, den_q[k]};

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        rem_q[k+1]  <= ge ? W'(trial - {1'b0, den_q[k]}) : trial[W-1:0];
        nlo_q[k+1]  <= nlo_q[k] << 1;
        quo_q[k+1]  <= {quo_q[k][W-2:0], ge};
        den_q[k+1]  <= den_q[k];
        neg_q[k+1]  <= neg_q[k];
        over_q[k+1] <= over_q[k];
        side_q[k+1] <= side_q[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q[k+1] <= vld_q[k];
      end
    end
  end

  // Round half away from zero, restore the sign and saturate.
  always_comb begin
    rnd     = {1'b0, rem_q[W]} >= ({1'b0, den_q[W]} - {1'b0, rem_q[W]});
    quo_rnd = {1'b0, quo_q[W]} + (W+1)'(rnd);
    sat     = over_q[W] || (quo_rnd > VMAX_X);
    if (neg_q[W]) begin
      res_d = sat ? VMIN : (~quo_rnd[W-1:0] + W'(1));
    end else begin
      res_d = sat ? VMAX : quo_rnd[W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      res_q      <= res_d;
      side_out_q <= side_q[W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else if (ctl_i.en) begin
      vld_out_q <= vld_q[W];
    end
  end

  assign quo_o  = res_q;
  assign side_o = side_out_q;
  assign vld_o  = vld_out_q;

endmodule

>>> hw/rtl/sor_pressure_cell_update_core.sv
// Top level of the pressure cell update core: one relaxation step per cell.
//
// Channel   Direction  Handshake                       Payload
// s_axis    in         s_axis_tvalid_i/s_axis_tready_o tdata: pressures, rhs; tuser: fluid marks
// m_axis    out        m_axis_tvalid_o/m_axis_tready_i tdata: new pressure, residual; tuser: iso
// cfg       in         cfg_valid_i/cfg_ready_o         register index and write data
//
// One cell enters per cycle while the master side does not stall.
// The divider is the longest part of the pipeline: it resolves one quotient bit per pipeline stage.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
// A stall on the master side freezes every stage together, so nothing is lost or repeated.
`timescale 1ns / 1ps

module sor_pressure_cell_update_core #(
  parameter int FRAC_BITS   = 24,
  parameter int VALUE_WIDTH = 48
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // tdata: p_center, p_east, p_west, p_north, p_south, rhs_value, zero fill
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [((6*VALUE_WIDTH+7)/8)*8-1:0]   s_axis_tdata_i,
  // tuser: center_fluid, east_fluid, west_fluid, north_fluid, south_fluid
  input  logic [sorpcu_pkg::IN_USER_W-1:0]     s_axis_tuser_i,
  // tdata: new_pressure, residual_square, zero fill
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [((2*VALUE_WIDTH+6)/8)*8-1:0]   m_axis_tdata_o,
  // tuser: isolated_cell
  output logic [0:0]                           m_axis_tuser_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [sorpcu_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [sorpcu_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int W = VALUE_WIDTH;
  localparam int F = FRAC_BITS;
  localparam int OUT_DATA_W = ((2 * W + 6) / 8) * 8;
  localparam int XW = 65;

  localparam logic [W-1:0]  VMAX   = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  VMIN   = {1'b1, {(W-1){1'b0}}};
  localparam logic [XW-1:0] VMAX_X = XW'(VMAX);
  localparam logic [W-1:0]  ONE_Q  = W'(1) << F;

  typedef struct packed {
    logic [W-1:0] pc;
    logic [W-1:0] pe;
    logic [W-1:0] pw;
    logic [W-1:0] pn;
    logic [W-1:0] ps;
    logic [W-1:0] rhs;
    logic         fc;
    logic         fe;
    logic         fw;
    logic         fn;
    logic         fs;
  } cell_t;

  typedef struct packed {
    logic         iso;
    logic         fc;
    logic [W-1:0] rhs;
  } tail_t;

  typedef struct packed {
    logic         iso;
    logic         fc;
    logic [W-1:0] np;
  } final_t;

  localparam int CELL_W  = $bits(cell_t);
  localparam int TAIL_W  = $bits(tail_t);
  localparam int FINAL_W = $bits(final_t);

  // Saturating two's complement add and subtract.
  function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) begin
      return s[W] ? VMIN : VMAX;
    end
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] sat_sub(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) begin
      return s[W] ? VMIN : VMAX;
    end
    return s[W-1:0];
  endfunction

  // A register value above the largest value is held at it.
  function automatic logic [W-1:0] clamp_reg(input logic [XW-1:0] r);
    return (r > VMAX_X) ? VMAX : W'(r);
  endfunction

  logic [sorpcu_pkg::RELAX_W-1:0]  relax_q;
  logic [sorpcu_pkg::INV_SQ_W-1:0] inv_dx_q, inv_dy_q;
  logic [W-1:0] om_v, rdx_v, rdy_v, onem_v;
  logic         en;
  sorpcu_pkg::stage_ctl_t ctl_a, ctl_div, ctl_c, ctl_d, ctl_e;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relax_q  <= sorpcu_pkg::RELAX_RESET;
      inv_dx_q <= sorpcu_pkg::INV_SQ_RESET;
      inv_dy_q <= sorpcu_pkg::INV_SQ_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sorpcu_pkg::REG_RELAXATION: relax_q  <= cfg_data_i[sorpcu_pkg::RELAX_W-1:0];
        sorpcu_pkg::REG_INV_DX_SQ:  inv_dx_q <= cfg_data_i[sorpcu_pkg::INV_SQ_W-1:0];
        sorpcu_pkg::REG_INV_DY_SQ:  inv_dy_q <= cfg_data_i[sorpcu_pkg::INV_SQ_W-1:0];
        default: ;
      endcase
    end
  end

  assign om_v   = clamp_reg(XW'(relax_q));
  assign rdx_v  = clamp_reg(XW'(inv_dx_q));
  assign rdy_v  = clamp_reg(XW'(inv_dy_q));
  assign onem_v = sat_sub(ONE_Q, om_v);

  // The whole pipeline advances unless a finished result is waiting.
  logic out_vld_q;
  assign en              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // Stage 1: neighbour sums and divisor.
  cell_t        cell_in;
  logic [W:0]   d_sum;
  logic [W-1:0] s1_sx_q, s1_sy_q, s1_d_q;
  cell_t        s1_cell_q;
  logic         s1_vld_q;

  always_comb begin
    cell_in.pc  = s_axis_tdata_i[0*W +: W];
    cell_in.pe  = s_axis_tdata_i[1*W +: W];
    cell_in.pw  = s_axis_tdata_i[2*W +: W];
    cell_in.pn  = s_axis_tdata_i[3*W +: W];
    cell_in.ps  = s_axis_tdata_i[4*W +: W];
    cell_in.rhs = s_axis_tdata_i[5*W +: W];
    cell_in.fc  = s_axis_tuser_i[sorpcu_pkg::FLAG_CENTER];
    cell_in.fe  = s_axis_tuser_i[sorpcu_pkg::FLAG_EAST];
    cell_in.fw  = s_axis_tuser_i[sorpcu_pkg::FLAG_WEST];
    cell_in.fn  = s_axis_tuser_i[sorpcu_pkg::FLAG_NORTH];
    cell_in.fs  = s_axis_tuser_i[sorpcu_pkg::FLAG_SOUTH];
    // All terms are non-negative, so one clamp at the end suffices.
    d_sum = (cell_in.fe ? (W+1)'(rdx_v) : '0) + (cell_in.fw ? (W+1)'(rdx_v) : '0)
          + (cell_in.fn ? (W+1)'(rdy_v) : '0) + (cell_in.fs ? (W+1)'(rdy_v) : '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_sx_q   <= sat_add(cell_in.fe ? cell_in.pe : '0, cell_in.fw ? cell_in.pw : '0);
      s1_sy_q   <= sat_add(cell_in.fn ? cell_in.pn : '0, cell_in.fs ? cell_in.ps : '0);
      s1_d_q    <= (d_sum > {1'b0, VMAX}) ? VMAX : d_sum[W-1:0];
      s1_cell_q <= cell_in;
    end
  end

  // Neighbour sums scaled by the grid factors.
  logic [W-1:0]      mx_p, my_p, a_d;
  logic [CELL_W-1:0] a_cell;
  logic              mx_vld, my_vld;

  assign ctl_a = '{en: en, vld: s1_vld_q};

  sorpcu_mul #(.W(W), .F(F), .SIDE_W(CELL_W)) u_mul_sx (
    .clk_i, .rst_ni, .ctl_i(ctl_a), .a_i(s1_sx_q), .b_i(rdx_v), .side_i(s1_cell_q),
    .p_o(mx_p), .side_o(a_cell), .vld_o(mx_vld)
  );

  sorpcu_mul #(.W(W), .F(F), .SIDE_W(W)) u_mul_sy (
    .clk_i, .rst_ni, .ctl_i(ctl_a), .a_i(s1_sy_q), .b_i(rdy_v), .side_i(s1_d_q),
    .p_o(my_p), .side_o(a_d), .vld_o(my_vld)
  );

  // Stages 4 and 5: star sum minus right-hand side.
  logic [W-1:0] s4_t_q, s4_d_q, s5_s_q, s5_d_q;
  cell_t        s4_cell_q, s5_cell_q;
  logic         s4_vld_q, s5_vld_q, s5_iso_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_t_q    <= sat_add(mx_p, my_p);
      s4_d_q    <= a_d;
      s4_cell_q <= a_cell;
      s5_s_q    <= sat_sub(s4_t_q, s4_cell_q.rhs);
      s5_d_q    <= s4_d_q;
      s5_cell_q <= s4_cell_q;
      s5_iso_q  <= s4_d_q == '0;
    end
  end

  // Division by the divisor.
  logic [W-1:0]        quo;
  logic [CELL_W:0]     div_side;
  cell_t               div_cell;
  logic                div_iso, div_vld;

  assign ctl_div = '{en: en, vld: s5_vld_q};

  sorpcu_div #(.W(W), .F(F), .SIDE_W(CELL_W + 1)) u_div (
    .clk_i, .rst_ni, .ctl_i(ctl_div), .num_i(s5_s_q), .den_i(s5_d_q),
    .side_i({s5_iso_q, s5_cell_q}), .quo_o(quo), .side_o(div_side), .vld_o(div_vld)
  );

  assign div_cell = div_side[CELL_W-1:0];
  assign div_iso  = div_side[CELL_W];

  // Relaxation: omega times quotient plus (1 - omega) times old pressure.
  logic [W-1:0]      mo_p, mp_p;
  logic [CELL_W-1:0] c_cell;
  logic [0:0]        c_iso;
  logic              mo_vld, mp_vld;
  cell_t             c_cell_s;

  assign ctl_c = '{en: en, vld: div_vld};

  sorpcu_mul #(.W(W), .F(F), .SIDE_W(CELL_W)) u_mul_om (
    .clk_i, .rst_ni, .ctl_i(ctl_c), .a_i(om_v), .b_i(quo), .side_i(div_cell),
    .p_o(mo_p), .side_o(c_cell), .vld_o(mo_vld)
  );

  sorpcu_mul #(.W(W), .F(F), .SIDE_W(1)) u_mul_keep (
    .clk_i, .rst_ni, .ctl_i(ctl_c), .a_i(onem_v), .b_i(div_cell.pc), .side_i(div_iso),
    .p_o(mp_p), .side_o(c_iso), .vld_o(mp_vld)
  );

  assign c_cell_s = c_cell;

  // New pressure; non-fluid and isolated cells keep their value.
  logic [W-1:0] np_q;
  cell_t        np_cell_q;
  logic         np_iso_q, np_vld_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      np_q      <= (c_iso[0] || !c_cell_s.fc) ? c_cell_s.pc : sat_add(mp_p, mo_p);
      np_cell_q <= c_cell_s;
      np_iso_q  <= c_iso[0];
    end
  end

  // Differences to the neighbours, then the residual terms per axis.
  logic [W-1:0] df_e_q, df_w_q, df_n_q, df_s_q, df_np_q;
  cell_t        df_cell_q;
  logic         df_iso_q, df_vld_q;
  logic [W-1:0] tx_q, ty_q, t_np_q;
  tail_t        t_tail_q;
  logic         t_vld_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      df_e_q    <= sat_sub(np_cell_q.pe, np_q);
      df_w_q    <= sat_sub(np_q, np_cell_q.pw);
      df_n_q    <= sat_sub(np_cell_q.pn, np_q);
      df_s_q    <= sat_sub(np_q, np_cell_q.ps);
      df_np_q   <= np_q;
      df_cell_q <= np_cell_q;
      df_iso_q  <= np_iso_q;
      tx_q      <= sat_sub(df_cell_q.fe ? df_e_q : '0, df_cell_q.fw ? df_w_q : '0);
      ty_q      <= sat_sub(df_cell_q.fn ? df_n_q : '0, df_cell_q.fs ? df_s_q : '0);
      t_np_q    <= df_np_q;
      t_tail_q  <= '{iso: df_iso_q, fc: df_cell_q.fc, rhs: df_cell_q.rhs};
    end
  end

  // Residual terms scaled by the grid factors.
  logic [W-1:0]      mtx_p, mty_p, d_np;
  logic [TAIL_W-1:0] d_tail;
  logic              mtx_vld, mty_vld;
  tail_t             d_tail_s;

  assign ctl_d = '{en: en, vld: t_vld_q};

  sorpcu_mul #(.W(W), .F(F), .SIDE_W(W)) u_mul_tx (
    .clk_i, .rst_ni, .ctl_i(ctl_d), .a_i(tx_q), .b_i(rdx_v), .side_i(t_np_q),
    .p_o(mtx_p), .side_o(d_np), .vld_o(mtx_vld)
  );

  sorpcu_mul #(.W(W), .F(F), .SIDE_W(TAIL_W)) u_mul_ty (
    .clk_i, .rst_ni, .ctl_i(ctl_d), .a_i(ty_q), .b_i(rdy_v), .side_i(t_tail_q),
    .p_o(mty_p), .side_o(d_tail), .vld_o(mty_vld)
  );

  assign d_tail_s = d_tail;

  // Residual: scaled sum minus right-hand side.
  logic [W-1:0] u_q, u_np_q, r_q;
  tail_t        u_tail_q;
  final_t       r_fin_q;
  logic         u_vld_q, r_vld_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      u_q      <= sat_add(mtx_p, mty_p);
      u_np_q   <= d_np;
      u_tail_q <= d_tail_s;
      r_q      <= sat_sub(u_q, u_tail_q.rhs);
      r_fin_q  <= '{iso: u_tail_q.iso, fc: u_tail_q.fc, np: u_np_q};
    end
  end

  // Square of the residual.
  logic [W-1:0]       rr_p;
  logic [FINAL_W-1:0] e_fin;
  logic               rr_vld;
  final_t             e_fin_s;

  assign ctl_e = '{en: en, vld: r_vld_q};

  sorpcu_mul #(.W(W), .F(F), .SIDE_W(FINAL_W)) u_mul_rr (
    .clk_i, .rst_ni, .ctl_i(ctl_e), .a_i(r_q), .b_i(r_q), .side_i(r_fin_q),
    .p_o(rr_p), .side_o(e_fin), .vld_o(rr_vld)
  );

  assign e_fin_s = e_fin;

  // Output register.
  logic [W-1:0] out_np_q;
  logic [W-2:0] out_res_q;
  logic         out_iso_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_np_q  <= e_fin_s.np;
      out_res_q <= e_fin_s.fc ? rr_p[W-2:0] : '0;
      out_iso_q <= e_fin_s.fc && e_fin_s.iso;
    end
  end

  // Valid bits of the stages held in this module.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      np_vld_q  <= 1'b0;
      df_vld_q  <= 1'b0;
      t_vld_q   <= 1'b0;
      u_vld_q   <= 1'b0;
      r_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= s_axis_tvalid_i;
      s4_vld_q  <= mx_vld;
      s5_vld_q  <= s4_vld_q;
      np_vld_q  <= mo_vld;
      df_vld_q  <= np_vld_q;
      t_vld_q   <= df_vld_q;
      u_vld_q   <= mtx_vld;
      r_vld_q   <= u_vld_q;
      out_vld_q <= rr_vld;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OUT_DATA_W'({out_res_q, out_np_q});
  assign m_axis_tuser_o  = out_iso_q;

`ifndef ASSERT_OFF
  // Paired multipliers share one control and must stay in lock step.
  a_pair_sum_vld : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mx_vld == my_vld) else $error("star sum multipliers out of step");

  a_pair_relax_vld : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mo_vld == mp_vld) else $error("relaxation multipliers out of step");

  a_pair_res_vld : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mtx_vld == mty_vld) else $error("residual multipliers out of step");

  // An item leaving the relaxation multiplier on an advancing cycle reaches the
  // new pressure stage.
  a_np_vld_from_mul : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && mo_vld |=> np_vld_q) else $error("relaxed item lost before the pressure stage");
`endif

endmodule

>>> dv/tb_sor_pressure_cell_update_core.sv
// Self-checking testbench of the pressure cell update core.
`timescale 1ns / 1ps

module tb_sor_pressure_cell_update_core;

  localparam int VW = 48;
  localparam int FB = 24;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [VW-1:0] pc, pe, pw, pn, ps, rhs;
    logic [sorpcu_pkg::IN_USER_W-1:0] fluid;
  } cell_t;

  typedef struct {
    logic signed [VW-1:0] new_p;
    logic [VW-2:0]        res_sq;
    logic                 iso;
  } cell_result_t;

  localparam wide_t VMAX_W = (wide_t'(1) <<< (VW - 1)) - 1;
  localparam wide_t VMIN_W = -VMAX_W - 1;
  localparam wide_t ONE_W  = wide_t'(1) <<< FB;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [6*VW-1:0] s_axis_tdata_i = '0;
  logic [sorpcu_pkg::IN_USER_W-1:0] s_axis_tuser_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [2*VW-1:0] m_axis_tdata_o;
  logic [0:0] m_axis_tuser_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [sorpcu_pkg::CFG_IDX_W-1:0] cfg_index_i = sorpcu_pkg::REG_RELAXATION;
  logic [sorpcu_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  sor_pressure_cell_update_core #(.FRAC_BITS(FB), .VALUE_WIDTH(VW)) uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Register copies held by the predictor.
  logic [sorpcu_pkg::RELAX_W-1:0]  omega_q  = sorpcu_pkg::RELAX_RESET;
  logic [sorpcu_pkg::INV_SQ_W-1:0] rdx_q    = sorpcu_pkg::INV_SQ_RESET;
  logic [sorpcu_pkg::INV_SQ_W-1:0] rdy_q    = sorpcu_pkg::INV_SQ_RESET;

  cell_result_t expected_cells[$];
  int errors = 0, n_sent = 0, n_checked = 0, n_iso = 0, n_solid = 0;
  int burst_left = 0;
  bit no_gaps = 0;
  bit hold_req = 0, hold_done = 0;
  int hold_cnt = 0;

  // Saturating fixed-point helpers at the core's value width.
  function automatic wide_t sat(wide_t x);
    if (x > VMAX_W) return VMAX_W;
    if (x < VMIN_W) return VMIN_W;
    return x;
  endfunction

  function automatic wide_t fx_mul(wide_t a, wide_t b);
    wide_t m;
    m = (a < 0 ? -a : a) * (b < 0 ? -b : b);
    m = (m + (wide_t'(1) <<< (FB - 1))) >>> FB;
    return sat(((a < 0) != (b < 0)) ? -m : m);
  endfunction

  function automatic wide_t fx_div(wide_t n, wide_t d);
    wide_t u, q, r;
    u = (n < 0 ? -n : n) <<< FB;
    q = u / d;
    r = u - q * d;
    if (2 * r >= d) q = q + 1;
    return sat(n < 0 ? -q : q);
  endfunction

  // Relaxed pressure and residual for one cell under the current registers.
  function automatic cell_result_t relax_cell(cell_t c);
    cell_result_t o;
    wide_t om, rdx, rdy, pc, d, sx, sy, s, np, tx, ty, r, rr;
    om = wide_t'(omega_q);
    rdx = wide_t'(rdx_q);
    rdy = wide_t'(rdy_q);
    pc = wide_t'(c.pc);
    o.iso = 1'b0;
    o.new_p = c.pc;
    o.res_sq = '0;
    if (!c.fluid[sorpcu_pkg::FLAG_CENTER]) return o;
    d = 0; sx = 0; sy = 0; tx = 0; ty = 0; np = pc;
    if (c.fluid[sorpcu_pkg::FLAG_EAST])  begin d = sat(d + rdx); sx = sat(sx + c.pe); end
    if (c.fluid[sorpcu_pkg::FLAG_WEST])  begin d = sat(d + rdx); sx = sat(sx + c.pw); end
    if (c.fluid[sorpcu_pkg::FLAG_NORTH]) begin d = sat(d + rdy); sy = sat(sy + c.pn); end
    if (c.fluid[sorpcu_pkg::FLAG_SOUTH]) begin d = sat(d + rdy); sy = sat(sy + c.ps); end
    if (d <= 0) begin
      o.iso = 1'b1;
    end else begin
      s = sat(sat(fx_mul(sx, rdx) + fx_mul(sy, rdy)) - wide_t'(c.rhs));
      np = sat(fx_mul(sat(ONE_W - om), pc) + fx_mul(om, fx_div(s, d)));
    end
    if (c.fluid[sorpcu_pkg::FLAG_EAST])  tx = sat(tx + sat(wide_t'(c.pe) - np));
    if (c.fluid[sorpcu_pkg::FLAG_WEST])  tx = sat(tx - sat(np - wide_t'(c.pw)));
    if (c.fluid[sorpcu_pkg::FLAG_NORTH]) ty = sat(ty + sat(wide_t'(c.pn) - np));
    if (c.fluid[sorpcu_pkg::FLAG_SOUTH]) ty = sat(ty - sat(np - wide_t'(c.ps)));
    r = sat(sat(fx_mul(tx, rdx) + fx_mul(ty, rdy)) - wide_t'(c.rhs));
    rr = fx_mul(r, r);
    o.new_p = np[VW-1:0];
    o.res_sq = rr[VW-2:0];
    return o;
  endfunction

  // Sends one cell, in bursts separated by random gaps unless no_gaps is set.
  task automatic send_cell(cell_t c);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 6);
      if (!no_gaps && gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {c.rhs, c.ps, c.pn, c.pw, c.pe, c.pc};
    s_axis_tuser_i <= c.fluid;
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_cells.push_back(relax_cell(c));
    n_sent++;
    if (!c.fluid[sorpcu_pkg::FLAG_CENTER]) n_solid++;
  endtask

  // Lowers the input and lets every outstanding cell come out.
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [sorpcu_pkg::CFG_IDX_W-1:0] idx,
                           logic [sorpcu_pkg::CFG_DATA_W-1:0] val);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      sorpcu_pkg::REG_RELAXATION: omega_q = val[sorpcu_pkg::RELAX_W-1:0];
      sorpcu_pkg::REG_INV_DX_SQ:  rdx_q = val;
      sorpcu_pkg::REG_INV_DY_SQ:  rdy_q = val;
      default: ;
    endcase
  endtask

  function automatic logic signed [VW-1:0] rand_value();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: case ($urandom_range(0, 3))
           0: return VMAX_W[VW-1:0];
           1: return VMIN_W[VW-1:0];
           2: return '0;
           default: return '1;
         endcase
      1, 2: return VW'($signed(raw[31:0]));
      3: return VW'($signed(raw[41:0]));
      default: return raw[VW-1:0];
    endcase
  endfunction

  function automatic cell_t rand_cell();
    cell_t c;
    c.pc = rand_value(); c.pe = rand_value(); c.pw = rand_value();
    c.pn = rand_value(); c.ps = rand_value(); c.rhs = rand_value();
    // Mostly fluid stars, with obstacles and solid cells mixed in.
    c.fluid = ($urandom_range(0, 3) == 0) ? sorpcu_pkg::IN_USER_W'($urandom) : '1;
    return c;
  endfunction

  function automatic cell_t make_cell(logic signed [VW-1:0] p, logic signed [VW-1:0] nb,
                                      logic signed [VW-1:0] rhs,
                                      logic [sorpcu_pkg::IN_USER_W-1:0] fl);
    cell_t c;
    c.pc = p; c.pe = nb; c.pw = -nb; c.pn = nb >>> 1; c.ps = nb + 1;
    c.rhs = rhs; c.fluid = fl;
    return c;
  endfunction

  // Solid cells, isolated cells, each single neighbour, value extremes and random cells.
  task automatic test_directed();
    logic signed [VW-1:0] vmax, vmin;
    vmax = VMAX_W[VW-1:0];
    vmin = VMIN_W[VW-1:0];
    send_cell(make_cell(48'sd123456789, 48'sd5, 48'sd0, 5'b11110));
    send_cell(make_cell(vmin, vmax, vmax, 5'b00000));
    send_cell(make_cell(48'sd16777216, 48'sd7, 48'sd3, 5'b00001));
    send_cell(make_cell(vmax, vmax, vmin, 5'b00001));
    for (int i = sorpcu_pkg::FLAG_EAST; i <= sorpcu_pkg::FLAG_SOUTH; i++)
      send_cell(make_cell(48'sd1000000, 48'sd33554432, -48'sd777, 5'b00001 | (5'b1 << i)));
    send_cell(make_cell(48'sd0, 48'sd16777216, 48'sd16777216, 5'b11111));
    send_cell(make_cell(vmax, vmax, vmin, 5'b11111));
    send_cell(make_cell(vmin, vmin, vmax, 5'b11111));
    send_cell(make_cell(vmin, vmax, vmin, 5'b11111));
    send_cell(make_cell(-48'sd1, -48'sd1, -48'sd1, 5'b11111));
    send_cell(make_cell(vmax, 48'sd0, vmax, 5'b10101));
    send_cell(make_cell(vmin, vmin, 48'sd0, 5'b01011));
    for (int i = 0; i < 6; i++) send_cell(rand_cell());
  endtask

  // Register extremes, including zero spacing terms that leave no divisor.
  task automatic test_register_extremes();
    write_reg(sorpcu_pkg::REG_RELAXATION, 47'd33554432);
    write_reg(sorpcu_pkg::REG_INV_DX_SQ, {sorpcu_pkg::INV_SQ_W{1'b1}});
    write_reg(sorpcu_pkg::REG_INV_DY_SQ, 47'd1);
    test_directed();
    write_reg(sorpcu_pkg::REG_RELAXATION, 47'd0);
    write_reg(sorpcu_pkg::REG_INV_DX_SQ, 47'd0);
    write_reg(sorpcu_pkg::REG_INV_DY_SQ, {sorpcu_pkg::INV_SQ_W{1'b1}});
    test_directed();
    write_reg(sorpcu_pkg::REG_RELAXATION, 47'h3FFFFFF);
    write_reg(sorpcu_pkg::REG_INV_DX_SQ, 47'd0);
    write_reg(sorpcu_pkg::REG_INV_DY_SQ, 47'd0);
    test_directed();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_cell(rand_cell());
  endtask

  // Long receiver hold-off while cells keep coming back to back.
  task automatic test_backpressure();
    no_gaps = 1;
    hold_req = 1;
    test_random(200);
    no_gaps = 0;
  endtask

  task automatic random_registers();
    write_reg(sorpcu_pkg::REG_RELAXATION,
              sorpcu_pkg::CFG_DATA_W'($urandom_range(0, 33554432)));
    write_reg(sorpcu_pkg::REG_INV_DX_SQ, ($urandom_range(0, 7) == 0) ?
              sorpcu_pkg::CFG_DATA_W'({$urandom, $urandom}) :
              sorpcu_pkg::CFG_DATA_W'($urandom_range(1, 1 << 28)));
    write_reg(sorpcu_pkg::REG_INV_DY_SQ, ($urandom_range(0, 7) == 0) ?
              sorpcu_pkg::CFG_DATA_W'({$urandom, $urandom}) :
              sorpcu_pkg::CFG_DATA_W'($urandom_range(1, 1 << 28)));
  endtask

  // Receiver: stall pattern changing at random, plus one long hold-off.
  initial begin
    int mode;
    mode = 0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready_i <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_cnt = 400;
        m_axis_tready_i <= 1'b0;
      end else begin
        case (mode)
          0: m_axis_tready_i <= 1'b1;
          1: m_axis_tready_i <= ($urandom_range(0, 9) > 2);
          default: m_axis_tready_i <= ($urandom_range(0, 9) > 6);
        endcase
      end
    end
  end

  // Compares each result transaction with the oldest expected cell.
  always @(posedge clk_i) begin
    cell_result_t e;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_cells.size() == 0) begin
        $display("%0t: unexpected result tdata=%h", $time, m_axis_tdata_o);
        errors++;
      end else begin
        e = expected_cells.pop_front();
        n_checked++;
        if (e.iso) n_iso++;
        if (m_axis_tdata_o[VW-1:0] !== e.new_p) begin
          $display("%0t: new_pressure expected %h actual %h", $time, e.new_p,
                   m_axis_tdata_o[VW-1:0]);
          errors++;
        end
        if (m_axis_tdata_o[2*VW-2:VW] !== e.res_sq) begin
          $display("%0t: residual_square expected %h actual %h", $time, e.res_sq,
                   m_axis_tdata_o[2*VW-2:VW]);
          errors++;
        end
        if (m_axis_tuser_o[0] !== e.iso) begin
          $display("%0t: isolated_cell expected %b actual %b", $time, e.iso,
                   m_axis_tuser_o[0]);
          errors++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_backpressure();
    test_random(500);
    test_register_extremes();
    for (int k = 0; k < 3; k++) begin
      random_registers();
      test_random(450);
    end
    wait_drained();
    if (expected_cells.size() != 0) errors++;
    $display("Covered %0d cells (%0d solid, %0d isolated) over several register settings,",
             n_sent, n_solid, n_iso);
    $display("%0d results checked, with a long output hold-off and random stalls.", n_checked);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
